FILE: sv/slipc_pkg.sv
// Shared types, SLIP byte codes and result helpers for the SLIP frame codec.
// No dependencies; imported by every module of the codec.
package slipc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 1024;
  localparam int LEN_W = 11;
  localparam int RES_SLOTS = 3;

  localparam logic [7:0] BYTE_END = 8'hC0;
  localparam logic [7:0] BYTE_ESC = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_ESC  = 2'd2
  } status_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             valid;
    logic             done;
    status_t          status;
    logic [LEN_W-1:0] length;
  } result_t;

  function automatic result_t res_none();
    result_t r;
    r.data   = 8'h00;
    r.valid  = 1'b0;
    r.done   = 1'b0;
    r.status = ST_OK;
    r.length = '0;
    return r;
  endfunction

  function automatic result_t res_byte(logic [7:0] b);
    result_t r;
    r       = res_none();
    r.data  = b;
    r.valid = 1'b1;
    return r;
  endfunction

endpackage

FILE: sv/slip_frame_codec.sv
// SLIP frame codec top level: input skid register, frame core, result queue.
// Depends on slipc_pkg, slipc_core and slipc_outq.
//
// Input channel s_*: one source byte per beat. s_tdata carries the byte,
// s_tuser the direction (0 encode, 1 decode), s_tlast the final byte of a frame.
// Output channel m_*: one result per beat. m_tdata carries the produced byte,
// the frame status and the frame length; m_tuser flags a produced byte and
// m_tlast the closing result of a frame.
// A beat passes the input register, then the result queue, before its first
// result is offered. Throughput: one input beat per cycle while each beat
// gives at most one result and the receiver does not stall; a beat giving
// more (an escaped byte, or a closing beat that also gives a byte) holds the
// next beat until the result queue, at one result per cycle, is on its last.
// Encoder and decoder keep separate frame state, so directions may interleave.
// Reset clears both frame states and empties all registers; s_tready is held
// low during reset and rises in the first cycle after it.
// When the receiver stalls the queued results hold, the input register and a
// one-beat skid register fill, then s_tready drops.
module slip_frame_codec import slipc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tuser,   // [0] mode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [9:8] frame_status, [20:10] frame_length
  output logic        m_tuser,   // [0] byte_valid
  output logic        m_tlast
);

  item_t      in_item;
  item_t      main_item;
  item_t      skid_item;
  logic       main_valid;
  logic       skid_valid;
  logic       accept;
  logic       load;
  logic       can_load;
  result_t    res [RES_SLOTS];
  logic [1:0] n;
  result_t    head;

  assign in_item.mode = s_tuser;
  assign in_item.data = s_tdata;
  assign in_item.last = s_tlast;

  assign s_tready = !rst && !skid_valid;
  assign accept = s_tvalid && s_tready;
  assign load = main_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || load) begin
      main_valid <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || load) begin
      main_item <= skid_valid ? skid_item : in_item;
    end else if (accept) begin
      skid_item <= in_item;
    end
  end

  slipc_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (load),
    .item (main_item),
    .res  (res),
    .n    (n)
  );

  slipc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res      (res),
    .n        (n),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {3'b000, head.length, head.status, head.data};
  assign m_tuser = head.valid;
  assign m_tlast = head.done;

endmodule

FILE: sv/slipc_core.sv
// Encoder and decoder frame state with the per-beat result builder.
// Depends on slipc_pkg.
module slipc_core import slipc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t res [RES_SLOTS],
  output logic [1:0] n
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W:0] ENC_LIMIT = (CNT_W + 1)'(MAX_FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] DEC_LIMIT = CNT_W'(MAX_FRAME_BYTES);

  logic [CNT_W-1:0] enc_count, enc_count_next;
  logic             enc_overflow, enc_overflow_next;
  logic [CNT_W-1:0] dec_count, dec_count_next;
  logic             dec_escape_pending, dec_escape_pending_next;
  status_t          dec_status, dec_status_next;

  logic             special;
  logic [CNT_W:0]   enc_sum;
  logic             have;
  logic [7:0]       dec_val;
  logic [1:0]       k;

  assign special = (item.data == BYTE_END) || (item.data == BYTE_ESC);
  assign enc_sum = {1'b0, enc_count} + (special ? (CNT_W + 1)'(2) : (CNT_W + 1)'(1));

  always_comb begin
    for (int i = 0; i < RES_SLOTS; i++) begin
      res[i] = res_none();
    end
    k = 2'd0;
    have = 1'b0;
    dec_val = 8'h00;
    enc_count_next = enc_count;
    enc_overflow_next = enc_overflow;
    dec_count_next = dec_count;
    dec_escape_pending_next = dec_escape_pending;
    dec_status_next = dec_status;
    if (item.mode == MODE_ENCODE) begin
      if (!enc_overflow) begin
        if (enc_sum <= ENC_LIMIT) begin
          if (special) begin
            res[0] = res_byte(BYTE_ESC);
            res[1] = res_byte((item.data == BYTE_END) ? BYTE_ESC_END : BYTE_ESC_ESC);
            k = 2'd2;
          end else begin
            res[0] = res_byte(item.data);
            k = 2'd1;
          end
          enc_count_next = enc_sum[CNT_W-1:0];
        end else begin
          enc_overflow_next = 1'b1;
        end
      end
      if (item.last) begin
        res[k] = res_byte(BYTE_END);
        res[k].done = 1'b1;
        res[k].status = enc_overflow_next ? ST_OVERFLOW : ST_OK;
        res[k].length = LEN_W'(32'(enc_count_next) + 32'd1);
        k = k + 2'd1;
        enc_count_next = '0;
        enc_overflow_next = 1'b0;
      end
    end else begin
      if (dec_status == ST_OK) begin
        if (dec_escape_pending) begin
          dec_escape_pending_next = 1'b0;
          if (item.data == BYTE_ESC_END) begin
            dec_val = BYTE_END;
            have = 1'b1;
          end else if (item.data == BYTE_ESC_ESC) begin
            dec_val = BYTE_ESC;
            have = 1'b1;
          end else begin
            dec_status_next = ST_BAD_ESC;
          end
        end else if (item.data == BYTE_ESC) begin
          dec_escape_pending_next = 1'b1;
        end else if (item.data != BYTE_END) begin
          dec_val = item.data;
          have = 1'b1;
        end
        if (have) begin
          if (dec_count < DEC_LIMIT) begin
            res[0] = res_byte(dec_val);
            k = 2'd1;
            dec_count_next = dec_count + CNT_W'(1);
          end else begin
            dec_status_next = ST_OVERFLOW;
          end
        end
      end
      if (item.last) begin
        if (dec_status_next == ST_OK && dec_escape_pending_next) begin
          dec_status_next = ST_BAD_ESC;
        end
        res[k].done = 1'b1;
        res[k].status = dec_status_next;
        res[k].length = LEN_W'(32'(dec_count_next));
        k = k + 2'd1;
        dec_count_next = '0;
        dec_escape_pending_next = 1'b0;
        dec_status_next = ST_OK;
      end
    end
  end

  assign n = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_count <= '0;
      enc_overflow <= 1'b0;
      dec_count <= '0;
      dec_escape_pending <= 1'b0;
      dec_status <= ST_OK;
    end else if (fire) begin
      enc_count <= enc_count_next;
      enc_overflow <= enc_overflow_next;
      dec_count <= dec_count_next;
      dec_escape_pending <= dec_escape_pending_next;
      dec_status <= dec_status_next;
    end
  end

  a_enc_room: assert property (@(posedge clk) disable iff (rst)
    {1'b0, enc_count} <= ENC_LIMIT)
    else $error("encoder count past room for END");

  a_dec_room: assert property (@(posedge clk) disable iff (rst)
    dec_count <= DEC_LIMIT)
    else $error("decoder count past frame limit");

  a_pending_ok: assert property (@(posedge clk) disable iff (rst)
    dec_escape_pending |-> dec_status == ST_OK)
    else $error("escape pending after frame error");

  a_last_result: assert property (@(posedge clk) disable iff (rst)
    fire && item.last |-> n != 2'd0 && res[n - 2'd1].done)
    else $error("frame end beat without closing result");

  a_enc_clear: assert property (@(posedge clk) disable iff (rst)
    fire && item.last && item.mode == MODE_ENCODE |=> enc_count == '0 && !enc_overflow)
    else $error("encoder state not cleared at frame end");

endmodule

FILE: sv/slipc_outq.sv
// Result register bank: holds up to three results of one beat, sends one per cycle
// while m_tready is high. Depends on slipc_pkg.
module slipc_outq import slipc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res [RES_SLOTS],
  input  logic [1:0] n,
  output logic       can_load,
  output logic       m_tvalid,
  input  logic       m_tready,
  output result_t    head
);

  result_t    slot [RES_SLOTS];
  logic [1:0] count;
  logic       take;

  assign m_tvalid = count != 2'd0;
  assign take = m_tvalid && m_tready;
  assign can_load = (count == 2'd0) || (count == 2'd1 && m_tready);
  assign head = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= n;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= res;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

FILE: verif/slip_frame_codec_test.sv
// Self-checking testbench for slip_frame_codec: encode and decode frames, escape and
// overflow cases, random stalls on both streams. Depends on slipc_pkg and the codec RTL.
`timescale 1ns / 1ps

module slip_frame_codec_test;
  import slipc_pkg::*;

  localparam int FRAME_MAX = MAX_FRAME_BYTES_DEF;

  class slip_scoreboard;
    int unsigned enc_len;
    bit          enc_ovf;
    int unsigned dec_len;
    bit          dec_esc;
    status_t     dec_st;
    result_t     pending_results[$];
    int          errors;
    int          checked;

    function new();
      enc_len = 0;
      enc_ovf = 1'b0;
      dec_len = 0;
      dec_esc = 1'b0;
      dec_st  = ST_OK;
      errors  = 0;
      checked = 0;
    endfunction

    function void push(logic [7:0] b, logic v, logic d, status_t st, int unsigned len);
      result_t r;
      r.data   = b;
      r.valid  = v;
      r.done   = d;
      r.status = st;
      r.length = len[LEN_W-1:0];
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Work out the results of one accepted input beat.
    function void note_beat(logic mode, logic [7:0] b, logic last);
      bit          special;
      int unsigned need;
      bit          have;
      logic [7:0]  v;
      if (mode == MODE_ENCODE) begin
        if (!enc_ovf) begin
          special = (b == BYTE_END) || (b == BYTE_ESC);
          need    = special ? 2 : 1;
          if (enc_len + need <= FRAME_MAX - 1) begin
            if (special) begin
              push(BYTE_ESC, 1'b1, 1'b0, ST_OK, 0);
              push((b == BYTE_END) ? BYTE_ESC_END : BYTE_ESC_ESC, 1'b1, 1'b0, ST_OK, 0);
            end else begin
              push(b, 1'b1, 1'b0, ST_OK, 0);
            end
            enc_len += need;
          end else begin
            enc_ovf = 1'b1;
          end
        end
        if (last) begin
          push(BYTE_END, 1'b1, 1'b1, enc_ovf ? ST_OVERFLOW : ST_OK, enc_len + 1);
          enc_len = 0;
          enc_ovf = 1'b0;
        end
      end else begin
        if (dec_st == ST_OK) begin
          have = 1'b0;
          v    = 8'h00;
          if (dec_esc) begin
            dec_esc = 1'b0;
            if (b == BYTE_ESC_END) begin
              v    = BYTE_END;
              have = 1'b1;
            end else if (b == BYTE_ESC_ESC) begin
              v    = BYTE_ESC;
              have = 1'b1;
            end else begin
              dec_st = ST_BAD_ESC;
            end
          end else if (b == BYTE_ESC) begin
            dec_esc = 1'b1;
          end else if (b != BYTE_END) begin
            v    = b;
            have = 1'b1;
          end
          if (have) begin
            if (dec_len < FRAME_MAX) begin
              push(v, 1'b1, 1'b0, ST_OK, 0);
              dec_len++;
            end else begin
              dec_st = ST_OVERFLOW;
            end
          end
        end
        if (last) begin
          if (dec_st == ST_OK && dec_esc) dec_st = ST_BAD_ESC;
          push(8'h00, 1'b0, 1'b1, dec_st, dec_len);
          dec_len = 0;
          dec_esc = 1'b0;
          dec_st  = ST_OK;
        end
      end
    endfunction

    // Compare one accepted output beat with the oldest pending result.
    task check_beat(logic [23:0] tdata, logic tuser, logic tlast);
      result_t exp_r;
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tdata=%h tuser=%b tlast=%b",
                                  tdata, tuser, tlast));
      end else begin
        exp_r = pending_results.pop_front();
        if (tdata[7:0] !== exp_r.data)
          report_mismatch($sformatf("out_byte %h, want %h", tdata[7:0], exp_r.data));
        if (tuser !== exp_r.valid)
          report_mismatch($sformatf("byte_valid %b, want %b", tuser, exp_r.valid));
        if (tlast !== exp_r.done)
          report_mismatch($sformatf("frame_done %b, want %b", tlast, exp_r.done));
        if (tdata[9:8] !== exp_r.status)
          report_mismatch($sformatf("frame_status %0d, want %0d", tdata[9:8], exp_r.status));
        if (tdata[20:10] !== exp_r.length)
          report_mismatch($sformatf("frame_length %0d, want %0d", tdata[20:10],
                                    exp_r.length));
        if (tdata[23:21] !== 3'b000)
          report_mismatch($sformatf("tdata padding %b not zero", tdata[23:21]));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  slip_scoreboard sb = new();
  bit             quiet;
  logic [7:0]     frame_q[$];

  slip_frame_codec #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic send_beat(logic mode, logic [7:0] b, logic last);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_beat(mode, b, last);
  endtask

  task automatic send_frame(logic mode);
    for (int i = 0; i < frame_q.size(); i++)
      send_beat(mode, frame_q[i], i == frame_q.size() - 1);
  endtask

  // Byte with a strong bias toward the two SLIP specials.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return BYTE_END;
      1: return BYTE_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // kind 0..2: well formed; 3: broken escape or trailing escape or raw noise.
  task automatic build_frame(logic mode, int n, int kind);
    logic [7:0] b;
    int         flaw;
    frame_q.delete();
    if (mode == MODE_ENCODE) begin
      repeat (n) frame_q.push_back(pick_byte());
    end else begin
      flaw = $urandom_range(0, 2);
      if (kind == 3 && flaw == 2) begin
        repeat (n) frame_q.push_back(pick_byte());
      end else begin
        if ($urandom_range(0, 1)) frame_q.push_back(BYTE_END);
        repeat (n) begin
          b = pick_byte();
          if (b == BYTE_END) begin
            frame_q.push_back(BYTE_ESC);
            frame_q.push_back(BYTE_ESC_END);
          end else if (b == BYTE_ESC) begin
            frame_q.push_back(BYTE_ESC);
            frame_q.push_back(BYTE_ESC_ESC);
          end else begin
            frame_q.push_back(b);
          end
          if ($urandom_range(0, 15) == 0) frame_q.push_back(BYTE_END);
        end
        if (kind == 3 && flaw == 1) begin
          frame_q.push_back(BYTE_ESC);
        end else begin
          if (kind == 3) begin
            b = 8'($urandom_range(0, 255));
            if (b == BYTE_ESC_END || b == BYTE_ESC_ESC) b = b ^ 8'h10;
            frame_q.insert($urandom_range(0, frame_q.size()), b);
            frame_q.insert($urandom_range(0, frame_q.size() - 1), BYTE_ESC);
          end
          frame_q.push_back(BYTE_END);
        end
      end
    end
  endtask

  initial begin : receiver
    int stall_left;
    int hold_left;
    bit held;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.checked >= 100) begin
        held      = 1'b1;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("slip_frame_codec_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    int       sent;
    int       n;
    int       kind;
    logic     mode;
    logic [7:0] b;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = MODE_ENCODE;
    s_tlast  = 1'b0;
    quiet    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // encode: plain byte, both specials, specials closing a frame
    send_beat(MODE_ENCODE, 8'h00, 1'b1);
    send_beat(MODE_ENCODE, BYTE_END, 1'b0);
    send_beat(MODE_ENCODE, BYTE_ESC, 1'b0);
    send_beat(MODE_ENCODE, 8'hFF, 1'b1);
    send_beat(MODE_ENCODE, BYTE_END, 1'b1);
    send_beat(MODE_ENCODE, BYTE_ESC, 1'b1);
    // decode: leading end, both escape pairs, extremes, closing end
    send_beat(MODE_DECODE, BYTE_END, 1'b0);
    send_beat(MODE_DECODE, BYTE_ESC, 1'b0);
    send_beat(MODE_DECODE, BYTE_ESC_END, 1'b0);
    send_beat(MODE_DECODE, BYTE_ESC, 1'b0);
    send_beat(MODE_DECODE, BYTE_ESC_ESC, 1'b0);
    send_beat(MODE_DECODE, 8'h00, 1'b0);
    send_beat(MODE_DECODE, 8'hFF, 1'b0);
    send_beat(MODE_DECODE, BYTE_END, 1'b1);
    // decode: invalid escape, then later bytes dropped
    send_beat(MODE_DECODE, BYTE_ESC, 1'b0);
    send_beat(MODE_DECODE, 8'h41, 1'b0);
    send_beat(MODE_DECODE, 8'h42, 1'b0);
    send_beat(MODE_DECODE, BYTE_END, 1'b1);
    // decode: escape as the final byte
    send_beat(MODE_DECODE, 8'h55, 1'b0);
    send_beat(MODE_DECODE, BYTE_ESC, 1'b1);
    // interleaved directions
    send_beat(MODE_ENCODE, 8'h11, 1'b0);
    send_beat(MODE_DECODE, 8'h22, 1'b0);
    send_beat(MODE_ENCODE, 8'h33, 1'b1);
    send_beat(MODE_DECODE, BYTE_END, 1'b1);

    // encode up to the last free byte, then overflow
    frame_q.delete();
    repeat (511) frame_q.push_back($urandom_range(0, 1) ? BYTE_END : BYTE_ESC);
    frame_q.push_back(8'h41);
    frame_q.push_back(BYTE_END);
    repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
    send_frame(MODE_ENCODE);

    // decode past the length limit, then an invalid escape that must not win
    frame_q.delete();
    repeat (FRAME_MAX + 6) begin
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_END || b == BYTE_ESC) b = b ^ 8'h01;
      frame_q.push_back(b);
    end
    frame_q.push_back(BYTE_ESC);
    frame_q.push_back(8'h41);
    frame_q.push_back(BYTE_END);
    send_frame(MODE_DECODE);

    sent = 0;
    while (sent < 220) begin
      if (sent >= 180) quiet = 1'b1;
      mode = 1'($urandom_range(0, 1));
      n    = $urandom_range(1, 10);
      kind = $urandom_range(0, 3);
      build_frame(mode, n, kind);
      send_frame(mode);
      sent += frame_q.size();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("slip_frame_codec_test OK");
    end else begin
      $display("slip_frame_codec_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/slipc_pkg.sv
sv/slipc_core.sv
sv/slipc_outq.sv
sv/slip_frame_codec.sv
verif/slip_frame_codec_test.sv
